// ===== hw/rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pls_pkg
// shared constants, codes and control types for the pooled linked stack
// ---------------------------------------------------------------------------
package pls_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 64;
	localparam int ACT_W  = 2;

	localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic out_hold;
	} sts_t;

endpackage

// ===== hw/rtl/pls_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pls_ctrl
// sequencer: accept a transaction, then execute it once the result slot frees
// ---------------------------------------------------------------------------
module pls_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  pls_pkg::sts_t sts,
	output pls_pkg::cmd_t cmd
);

	pls_pkg::state_t state_q;
	pls_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pls_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pls_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = pls_pkg::ST_EXEC;
				end
			end
			pls_pkg::ST_EXEC: begin
				if (!sts.out_hold) begin
					state_nxt = pls_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pls_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.exec   = 1'b0;
		unique case (state_q)
			pls_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			pls_pkg::ST_EXEC: begin
				cmd.exec = !sts.out_hold;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/pls_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pls_dpath
// node pool memories, free-index stack, top pointer and result register
// ---------------------------------------------------------------------------
module pls_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pls_pkg::cmd_t               cmd,
	output pls_pkg::sts_t               sts,
	input  logic [pls_pkg::ACT_W-1:0]   in_action,
	input  logic [pls_pkg::DATA_W-1:0]  in_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pls_pkg::DATA_W-1:0]  out_value,
	output logic                        out_status
);

	localparam int IW = pls_pkg::IDX_W;
	localparam int CW = pls_pkg::CNT_W;
	localparam int DW = pls_pkg::DATA_W;
	localparam int D  = pls_pkg::DEPTH;

	// memories
	logic [DW-1:0] val_mem [D];
	logic [IW:0]   link_mem [D];
	logic [IW-1:0] fs_mem [D];

	// flop state
	logic [pls_pkg::ACT_W-1:0] act_q;
	logic [DW-1:0]             val_q;
	logic [IW-1:0]             top_idx_q;
	logic                      top_empty_q;
	logic [CW-1:0]             free_cnt_q;
	logic [D-1:0]              node_free_q;
	logic [D-1:0]              fs_vld_q;

	// registered read data
	logic [DW-1:0] val_rd_q;
	logic [IW:0]   link_rd_q;
	logic [IW-1:0] fs_rd_q;
	logic          fs_vld_rd_q;
	logic [IW-1:0] fs_def_q;

	logic [DW-1:0] res_val_q;
	logic          res_sts_q;
	logic          res_vld_q;

	logic [IW-1:0] fs_addr;
	logic [IW-1:0] push_idx;
	logic          top_live;
	logic          push_ok;
	logic          pop_ok;
	logic          peek_ok;

	assign fs_addr  = IW'(free_cnt_q - CW'(1));
	assign push_idx = fs_vld_rd_q ? fs_rd_q : fs_def_q;
	assign top_live = !top_empty_q && !node_free_q[top_idx_q];
	assign push_ok  = (act_q == pls_pkg::ACT_PUSH) && (free_cnt_q != '0);
	assign pop_ok   = (act_q == pls_pkg::ACT_POP) && top_live
		&& (free_cnt_q != CW'(D));
	assign peek_ok  = (act_q == pls_pkg::ACT_PEEK) && top_live;

	assign sts.out_hold = res_vld_q && !out_ready;

	// transaction capture and memory reads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q       <= in_action;
			val_q       <= in_value;
			val_rd_q    <= val_mem[top_idx_q];
			link_rd_q   <= link_mem[top_idx_q];
			fs_rd_q     <= fs_mem[fs_addr];
			fs_vld_rd_q <= fs_vld_q[fs_addr];
			fs_def_q    <= IW'(D - 1) - fs_addr;
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			val_mem[push_idx]  <= val_q;
			link_mem[push_idx] <= {top_empty_q, top_idx_q};
		end
		if (cmd.exec && pop_ok) begin
			fs_mem[free_cnt_q[IW-1:0]] <= top_idx_q;
		end
	end

	// pointer, count and flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_idx_q   <= '0;
			top_empty_q <= 1'b1;
			free_cnt_q  <= CW'(D);
			node_free_q <= '1;
			fs_vld_q    <= '0;
		end else if (cmd.exec) begin
			if (push_ok) begin
				top_idx_q             <= push_idx;
				top_empty_q           <= 1'b0;
				free_cnt_q            <= free_cnt_q - CW'(1);
				node_free_q[push_idx] <= 1'b0;
			end else if (pop_ok) begin
				top_idx_q                    <= link_rd_q[IW-1:0];
				top_empty_q                  <= link_rd_q[IW];
				free_cnt_q                   <= free_cnt_q + CW'(1);
				node_free_q[top_idx_q]       <= 1'b1;
				fs_vld_q[free_cnt_q[IW-1:0]] <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_val_q <= (pop_ok || peek_ok) ? val_rd_q : '0;
			res_sts_q <= !(push_ok || pop_ok || peek_ok);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.exec) begin
			res_vld_q <= 1'b1;
		end else if (out_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	assign out_valid  = res_vld_q;
	assign out_value  = res_val_q;
	assign out_status = res_sts_q;

endmodule

// ===== hw/rtl/pooled_linked_stack_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pooled_linked_stack_unit
// lifo stack of 64-bit values linked inside a pool of 16 nodes
// ---------------------------------------------------------------------------
// Each transaction is accepted in ST_IDLE, which issues the registered reads
// of the free-index, value and link memories, and is executed in ST_EXEC,
// which updates the pool and loads the result register. While a result waits to be
// taken the next transaction is still accepted; it finishes once the result
// register frees. The action code travels in s_tuser, the status flag in
// m_tuser. Reset takes effect at once, with no clearing pass.
module pooled_linked_stack_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] push_value
	input  logic [1:0]  s_tuser,  // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [63:0] read_value
	output logic [0:0]  m_tuser   // [0] status
);

	pls_pkg::cmd_t cmd;
	pls_pkg::sts_t sts;

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pls_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_action  (s_tuser),
		.in_value   (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (m_tuser[0])
	);

	a_exec_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && sts.out_hold))
		else $error("execute while result register is held");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready right after an accepted transaction");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.exec))
		else $error("result appeared without an execute cycle");

endmodule
